// ===== rtl/pnns_pkg.sv =====
// Shared types and constants for the periodic nearest-neighbor search block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pnns_pkg;

    // Default sizing, handed to the top level as parameter defaults.
    localparam int DEF_MAX_PARTICLES = 64;
    localparam int DEF_COORD_BITS    = 16;

    // Fixed field widths of the ports.
    localparam int COORD_W    = 16;
    localparam int BOX_W      = 16;
    localparam int DIST_W     = 32;
    localparam int IDX_MAX_W  = 6;   // index width at the largest frame size
    localparam int CNT_MAX_W  = 7;   // count width at the largest frame size
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;

    localparam logic [BOX_W-1:0] BOX_RESET = 16'hFFFF;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One closed frame, waiting for its search.
    typedef struct packed {
        logic                 bank;
        logic [CNT_MAX_W-1:0] count;
    } job_t;

    // Position store write from the front.
    typedef struct packed {
        logic                 en;
        logic                 bank;
        logic [IDX_MAX_W-1:0] idx;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } store_wr_t;

    // Search of one bank finished; the bank may be reloaded.
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    // Minimum-image separation along one axis: at most one correction by the box.
    function automatic logic signed [COORD_W+1:0] wrap_axis(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [BOX_W-1:0]   box
    );
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+1:0] w;
        logic signed [COORD_W+2:0] d2;
        logic signed [COORD_W+2:0] w2;
        logic signed [COORD_W+1:0] r;
        d  = $signed({2'b00, a}) - $signed({2'b00, b});
        w  = $signed({2'b00, box});
        d2 = {d, 1'b0};
        w2 = {w[COORD_W+1], w};
        // Both conditions come from the raw difference; they exclude each other.
        if (d2 > w2)
            r = d - w;
        else if (d2 <= -w2)
            r = d + w;
        else
            r = d;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pnns_front.sv =====
// Front part: accepts position beats, writes them to the banked store, closes frames.
// Depends on pnns_pkg for the store write, job and done types.
`default_nettype none

module pnns_front
    import pnns_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [COORD_W-1:0] x_coord,
    input  wire logic [COORD_W-1:0] y_coord,
    input  wire logic               last_particle,
    output store_wr_t               store_wr,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output job_t                    push_job,
    input  done_t                   done
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_bank_reg;
    logic             wr_bank_next;
    logic [1:0]       bank_busy_reg;
    logic [1:0]       bank_busy_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_after;

    // A bank is loaded only while no search owns it.
    assign in_ready = !bank_busy_reg[wr_bank_reg] && push_ready;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(MAX_PARTICLES);

    assign count_after = room ? count_reg + CNT_W'(1) : count_reg;

    // Positions beyond the frame size are dropped.
    always_comb
    begin
        store_wr.en   = accept && room;
        store_wr.bank = wr_bank_reg;
        store_wr.idx  = IDX_MAX_W'(count_reg[IDX_W-1:0]);
        store_wr.x    = x_coord;
        store_wr.y    = y_coord;
    end

    // A beat with the last flag closes the frame and hands it to the back.
    assign push_valid     = accept && last_particle;
    assign push_job.bank  = wr_bank_reg;
    assign push_job.count = CNT_MAX_W'(count_after);

    always_comb
    begin
        count_next     = count_reg;
        wr_bank_next   = wr_bank_reg;
        bank_busy_next = bank_busy_reg;
        if (done.valid)
        begin
            bank_busy_next[done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (last_particle)
            begin
                count_next                  = '0;
                wr_bank_next                = !wr_bank_reg;
                bank_busy_next[wr_bank_reg] = 1'b1;
            end
            else
            begin
                count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_bank_reg   <= 1'b0;
            bank_busy_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            wr_bank_reg   <= wr_bank_next;
            bank_busy_reg <= bank_busy_next;
        end
    end

    // The fill count never passes the frame size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("front: particle count beyond frame size");

    // Closing a frame restarts the count in the other bank.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |=> (count_reg == '0) && (wr_bank_reg != $past(wr_bank_reg)))
        else $error("front: frame close did not switch bank");

    // Only a bank under search can be released.
    assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> bank_busy_reg[done.bank])
        else $error("front: release of a bank that is not busy");

endmodule

`default_nettype wire

// ===== rtl/pnns_job_queue.sv =====
// Short queue of closed frames between the front and the back.
// Depends on pnns_pkg for job_t and the queue depth.
`default_nettype none

module pnns_job_queue
    import pnns_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = fill_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pnns_back.sv =====
// Back part: banked position store and the shared distance pipeline that
// searches one closed frame, particle by particle. Depends on pnns_pkg.
`default_nettype none

module pnns_back
    import pnns_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  store_wr_t                 store_wr,
    input  wire logic                 job_valid,
    output logic                      job_pop,
    input  job_t                      job,
    output done_t                     done,
    input  wire logic [BOX_W-1:0]     box_width,
    input  wire logic [BOX_W-1:0]     box_height,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [IDX_MAX_W-1:0]      particle_index,
    output logic [IDX_MAX_W-1:0]      neighbor_index,
    output logic [COORD_W-1:0]        abs_dx,
    output logic [COORD_W-1:0]        abs_dy,
    output logic [DIST_W-1:0]         dist_squared,
    output logic                      neighbor_found,
    output logic                      last_result
);

    localparam int IDX_W   = $clog2(MAX_PARTICLES);
    localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
    localparam int STORE_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int ADDR_W  = IDX_W + 1;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int DIFF_W  = COORD_W + 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ_I = 6'b000010,
        S_CAP_I  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_EMIT   = 6'b100000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic             job_bank_reg;
    logic [CNT_W-1:0] job_n_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              issue;
    logic              init_best;
    logic              emit;
    logic              last_i;
    logic              last_j;
    logic              pipe_busy;

    logic [2*STORE_W-1:0] mem [DEPTH];
    logic [2*STORE_W-1:0] rd_data_reg;
    logic [COORD_W-1:0]   rd_x;
    logic [COORD_W-1:0]   rd_y;
    logic [COORD_W-1:0]   xi_reg;
    logic [COORD_W-1:0]   yi_reg;

    // Distance pipeline: A read, B wrap, C magnitude, D squares, then compare.
    logic                     pa_valid_reg;
    logic [IDX_W-1:0]         pa_j_reg;
    logic                     pb_valid_reg;
    logic [IDX_W-1:0]         pb_j_reg;
    logic signed [DIFF_W-1:0] pb_dx_reg;
    logic signed [DIFF_W-1:0] pb_dy_reg;
    logic                     pc_valid_reg;
    logic [IDX_W-1:0]         pc_j_reg;
    logic [COORD_W-1:0]       pc_ax_reg;
    logic [COORD_W-1:0]       pc_ay_reg;
    logic                     pd_valid_reg;
    logic [IDX_W-1:0]         pd_j_reg;
    logic [COORD_W-1:0]       pd_ax_reg;
    logic [COORD_W-1:0]       pd_ay_reg;
    logic [DIST_W-1:0]        pd_sx_reg;
    logic [DIST_W-1:0]        pd_sy_reg;

    logic signed [DIFF_W-1:0] neg_dx;
    logic signed [DIFF_W-1:0] neg_dy;
    logic [DIST_W:0]          sum_sq;
    logic [DIST_W-1:0]        cand_dist;
    logic                     take;

    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic [COORD_W-1:0]   best_dx_reg;
    logic [COORD_W-1:0]   best_dy_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [IDX_MAX_W-1:0] out_particle_reg;
    logic [IDX_MAX_W-1:0] out_neighbor_reg;
    logic [COORD_W-1:0]   out_dx_reg;
    logic [COORD_W-1:0]   out_dy_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic                 out_found_reg;
    logic                 out_last_reg;

    // Position store: one write port for the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            mem[{store_wr.bank, store_wr.idx[IDX_W-1:0]}] <=
                {store_wr.x[STORE_W-1:0], store_wr.y[STORE_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[{job_bank_reg, rd_idx}];
        end
    end

    assign rd_x = COORD_W'(rd_data_reg[2*STORE_W-1:STORE_W]);
    assign rd_y = COORD_W'(rd_data_reg[STORE_W-1:0]);

    assign last_i    = (CNT_W'(i_reg) + CNT_W'(1)) == job_n_reg;
    assign last_j    = (CNT_W'(j_reg) + CNT_W'(1)) == job_n_reg;
    assign pipe_busy = pa_valid_reg || pb_valid_reg || pc_valid_reg || pd_valid_reg;

    // Sequencer over the particles of a frame and over their candidates.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        job_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = j_reg;
        issue      = 1'b0;
        init_best  = 1'b0;
        emit       = 1'b0;
        done.valid = 1'b0;
        done.bank  = job_bank_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    i_next     = '0;
                    state_next = S_READ_I;
                end
            end
            S_READ_I:
            begin
                rd_en      = 1'b1;
                rd_idx     = i_reg;
                state_next = S_CAP_I;
            end
            S_CAP_I:
            begin
                init_best  = 1'b1;
                j_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                issue = 1'b1;
                if (last_j)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit = 1'b1;
                    if (last_i)
                    begin
                        done.valid = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_READ_I;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a result waits here while the next search goes on.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Candidate distance: saturated sum of squares, lowest index wins ties.
    assign sum_sq    = {1'b0, pd_sx_reg} + {1'b0, pd_sy_reg};
    assign cand_dist = sum_sq[DIST_W] ? '1 : sum_sq[DIST_W-1:0];
    assign take      = pd_valid_reg && (!found_reg || (cand_dist < best_dist_reg));

    assign neg_dx = -pb_dx_reg;
    assign neg_dy = -pb_dy_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            job_bank_reg  <= 1'b0;
            job_n_reg     <= '0;
            pa_valid_reg  <= 1'b0;
            pb_valid_reg  <= 1'b0;
            pc_valid_reg  <= 1'b0;
            pd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            if (job_pop)
            begin
                job_bank_reg <= job.bank;
                job_n_reg    <= job.count[CNT_W-1:0];
            end
            pa_valid_reg  <= issue && (j_reg != i_reg);
            pb_valid_reg  <= pa_valid_reg;
            pc_valid_reg  <= pb_valid_reg;
            pd_valid_reg  <= pc_valid_reg;
            if (init_best)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload and running best.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CAP_I)
        begin
            xi_reg <= rd_x;
            yi_reg <= rd_y;
        end
        pa_j_reg  <= j_reg;
        pb_j_reg  <= pa_j_reg;
        pb_dx_reg <= wrap_axis(xi_reg, rd_x, box_width);
        pb_dy_reg <= wrap_axis(yi_reg, rd_y, box_height);
        pc_j_reg  <= pb_j_reg;
        pc_ax_reg <= pb_dx_reg[DIFF_W-1] ? neg_dx[COORD_W-1:0] : pb_dx_reg[COORD_W-1:0];
        pc_ay_reg <= pb_dy_reg[DIFF_W-1] ? neg_dy[COORD_W-1:0] : pb_dy_reg[COORD_W-1:0];
        pd_j_reg  <= pc_j_reg;
        pd_ax_reg <= pc_ax_reg;
        pd_ay_reg <= pc_ay_reg;
        pd_sx_reg <= DIST_W'(pc_ax_reg) * DIST_W'(pc_ax_reg);
        pd_sy_reg <= DIST_W'(pc_ay_reg) * DIST_W'(pc_ay_reg);
        if (init_best)
        begin
            best_idx_reg  <= i_reg;
            best_dist_reg <= '0;
            best_dx_reg   <= '0;
            best_dy_reg   <= '0;
        end
        else if (take)
        begin
            best_idx_reg  <= pd_j_reg;
            best_dist_reg <= cand_dist;
            best_dx_reg   <= pd_ax_reg;
            best_dy_reg   <= pd_ay_reg;
        end
        if (emit)
        begin
            out_particle_reg <= IDX_MAX_W'(i_reg);
            out_neighbor_reg <= IDX_MAX_W'(best_idx_reg);
            out_dx_reg       <= best_dx_reg;
            out_dy_reg       <= best_dy_reg;
            out_dist_reg     <= best_dist_reg;
            out_found_reg    <= found_reg;
            out_last_reg     <= last_i;
        end
    end

    assign out_valid      = out_valid_reg;
    assign particle_index = out_particle_reg;
    assign neighbor_index = out_neighbor_reg;
    assign abs_dx         = out_dx_reg;
    assign abs_dy         = out_dy_reg;
    assign dist_squared   = out_dist_reg;
    assign neighbor_found = out_found_reg;
    assign last_result    = out_last_reg;

    // The candidate counter stays inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(j_reg) < job_n_reg))
        else $error("back: candidate index beyond frame");

    // No distance work is left in flight once a frame is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pipe_busy)
        else $error("back: pipeline busy while idle");

    // Only a frame of one particle yields a result without a neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_last_reg && out_particle_reg == '0))
        else $error("back: missing neighbor in a frame of several particles");

endmodule

`default_nettype wire

// ===== rtl/periodic_nearest_neighbor_search.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------------
// input     | in        | in_valid / in_ready  | x_coord, y_coord, last_particle
// result    | out       | out_valid / out_ready| particle_index .. last_result (7 fields)
// config    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Loading accepts one beat per cycle while in_ready is high. A frame is searched by one
// shared distance pipeline, particle by particle: read the particle, scan its candidates,
// drain the pipeline and hand off the result before the next particle starts.
// The store has two banks, so the next frame loads while the previous one is searched;
// input stalls only when both banks hold frames. A result waiting in the output register
// stalls the search only at the hand-off of the following result.
// Reset clears control state only; there is no clearing pass. Config writes take effect
// at once and are accepted every cycle.
// Top level; instantiates pnns_front, pnns_job_queue and pnns_back, uses pnns_pkg.
`default_nettype none

module periodic_nearest_neighbor_search
    import pnns_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BOX_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [COORD_W-1:0]   x_coord,
    input  wire logic [COORD_W-1:0]   y_coord,
    input  wire logic                 last_particle,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [IDX_MAX_W-1:0]      particle_index,
    output logic [IDX_MAX_W-1:0]      neighbor_index,
    output logic [COORD_W-1:0]        abs_dx,
    output logic [COORD_W-1:0]        abs_dy,
    output logic [DIST_W-1:0]         dist_squared,
    output logic                      neighbor_found,
    output logic                      last_result
);

    logic [BOX_W-1:0] box_width_reg;
    logic [BOX_W-1:0] box_height_reg;
    store_wr_t        store_wr;
    logic             push_valid;
    logic             push_ready;
    job_t             push_job;
    logic             pop_valid;
    logic             pop_ready;
    job_t             pop_job;
    done_t            done;

    // Box registers accept a write beat every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg  <= BOX_RESET;
            box_height_reg <= BOX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                REG_BOX_HEIGHT: box_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Front: loads positions and closes frames.
    pnns_front #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .last_particle (last_particle),
        .store_wr      (store_wr),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job),
        .done          (done)
    );

    // Closed frames waiting for the search.
    pnns_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back: store and distance search.
    pnns_back #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_BITS    (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .store_wr       (store_wr),
        .job_valid      (pop_valid),
        .job_pop        (pop_ready),
        .job            (pop_job),
        .done           (done),
        .box_width      (box_width_reg),
        .box_height     (box_height_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .particle_index (particle_index),
        .neighbor_index (neighbor_index),
        .abs_dx         (abs_dx),
        .abs_dy         (abs_dy),
        .dist_squared   (dist_squared),
        .neighbor_found (neighbor_found),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire
